/* hw/rtl/active_second_order_perceptron_top_macros.svh */
// Assertion macros used by the checker of the perceptron block.
// Needs clk and rst_n to be visible at the place of use.
`ifndef ACTIVE_SECOND_ORDER_PERCEPTRON_TOP_MACROS_SVH
`define ACTIVE_SECOND_ORDER_PERCEPTRON_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASOP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASOP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/asop_pkg.sv */
// Shared types, constants and helpers of the active second-order perceptron.
// No dependencies.
`default_nettype none
package asop_pkg;

  localparam int DIM_DEFAULT     = 1024;
  localparam int MAX_NNZ_DEFAULT = 64;

  localparam int IDX_W   = 10;
  localparam int VAL_W   = 16;
  localparam int DRAW_W  = 16;
  localparam int CNT_W   = 32;
  localparam int ACC_W   = 48;
  localparam int DIVN_W  = 64;
  localparam int DIVD_W  = 32;
  localparam int MUL_W   = 48;
  localparam int CFG_IDX_W = 8;
  localparam int ENTRY_W = IDX_W + VAL_W;

  localparam logic [47:0] QCAP      = 48'h7FFF_FFFF_FFFF;
  localparam logic [31:0] SIGMA_ONE = 32'h0001_0000;

  localparam logic [CFG_IDX_W-1:0] REG_QUERY_MODE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUERY_BIAS = 8'd1;

  localparam logic [2:0] MODE_ALWAYS  = 3'd0;
  localparam logic [2:0] MODE_MARGIN  = 3'd1;
  localparam logic [2:0] MODE_FIXED   = 3'd2;
  localparam logic [2:0] MODE_MARGVAR = 3'd3;
  localparam logic [2:0] MODE_NORM    = 3'd4;

  localparam int CNT_TP    = 0;
  localparam int CNT_TN    = 1;
  localparam int CNT_FP    = 2;
  localparam int CNT_FN    = 3;
  localparam int CNT_QUERY = 4;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_FRD, ST_FDIV1, ST_FDIV2, ST_END, ST_M3A, ST_M3B,
    ST_SQRT, ST_M4DIV, ST_QMUL, ST_DECIDE, ST_UB, ST_UA, ST_UW, ST_OUT
  } state_t;

  typedef struct packed {
    logic              start;
    logic [DIVN_W-1:0] dividend;
    logic [DIVD_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             start;
    logic [MUL_W-1:0] a;
    logic [MUL_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              start;
    logic [DIVN_W-1:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

  // Q16.16 product, saturated to the query cap.
  function automatic logic [47:0] cap_q(input logic [2*MUL_W-1:0] prod);
    logic [2*MUL_W-17:0] sh;
    sh = prod[2*MUL_W-1:16];
    cap_q = (sh > (2*MUL_W-16)'(QCAP)) ? QCAP : sh[47:0];
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/asop_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
`default_nettype none
module asop_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* hw/rtl/asop_div.sv */
// Restoring divider, one quotient bit per cycle while busy; a new request is ignored while busy.
// Depends on asop_pkg.
`default_nettype none
module asop_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire asop_pkg::div_req_t          req,
  output logic      [asop_pkg::DIVN_W-1:0] quotient,
  output asop_pkg::unit_sts_t              sts
);

  localparam int NW = asop_pkg::DIVN_W;
  localparam int DW = asop_pkg::DIVD_W;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] quo_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] den_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [DW:0]   rem_sh;
  logic          fits;

  assign rem_sh = {rem_r, quo_r[NW-1]};
  assign fits   = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end else if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      rem_r <= fits ? DW'(rem_sh - {1'b0, den_r}) : rem_sh[DW-1:0];
      quo_r <= {quo_r[NW-2:0], fits};
    end else if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      den_r <= req.divisor;
    end
  end

  assign quotient = quo_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule
`default_nettype wire

/* hw/rtl/asop_mul.sv */
// Shift-and-add multiplier, one multiplier bit per cycle while busy, full-width product.
// Depends on asop_pkg.
`default_nettype none
module asop_mul (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire asop_pkg::mul_req_t           req,
  output logic      [2*asop_pkg::MUL_W-1:0] product,
  output asop_pkg::unit_sts_t               sts
);

  localparam int MW = asop_pkg::MUL_W;
  localparam int CW = $clog2(MW + 1);

  logic [2*MW-1:0] acc_r;
  logic [2*MW-1:0] a_r;
  logic [MW-1:0]   b_r;
  logic [CW-1:0]   cnt_r;
  logic            busy_r;
  logic            done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end else if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(MW);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      if (b_r[0]) begin
        acc_r <= acc_r + a_r;
      end
      a_r <= {a_r[2*MW-2:0], 1'b0};
      b_r <= {1'b0, b_r[MW-1:1]};
    end else if (req.start) begin
      acc_r <= '0;
      a_r   <= (2*MW)'(req.a);
      b_r   <= req.b;
    end
  end

  assign product  = acc_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule
`default_nettype wire

/* hw/rtl/asop_sqrt.sv */
// Truncating integer square root, one result bit per cycle while busy.
// Depends on asop_pkg.
`default_nettype none
module asop_sqrt (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire asop_pkg::sqrt_req_t           req,
  output logic      [asop_pkg::DIVN_W/2-1:0] root,
  output asop_pkg::unit_sts_t                sts
);

  localparam int NW = asop_pkg::DIVN_W;
  localparam int CW = $clog2(NW / 2 + 1);

  logic [NW-1:0] x_r;
  logic [NW-1:0] r_r;
  logic [NW-1:0] bit_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [NW-1:0] trial;

  assign trial = r_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end else if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW / 2);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      if (x_r >= trial) begin
        x_r <= x_r - trial;
        r_r <= {1'b0, r_r[NW-1:1]} + bit_r;
      end else begin
        r_r <= {1'b0, r_r[NW-1:1]};
      end
      bit_r <= {2'b00, bit_r[NW-1:2]};
    end else if (req.start) begin
      x_r   <= req.radicand;
      r_r   <= '0;
      bit_r <= {2'b01, {(NW-2){1'b0}}};
    end
  end

  assign root     = r_r[NW/2-1:0];
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule
`default_nettype wire

/* hw/rtl/active_second_order_perceptron_top.sv */
// Per feature: an accept state, a weight/sigma read state and two divisions.
// The last feature adds the query rule (mode 3: three multiplies; mode 4: a square root,
// a division unless the root is zero, and a multiply), then the mistake update in three
// states per buffered feature, and an output state. One item at a time.
// After reset a clearing pass over all DIM entries loads weights and sigma; inputs wait.
// Depends on asop_pkg, asop_ram, asop_div, asop_mul, asop_sqrt.
`default_nettype none
module active_second_order_perceptron_top #(
  parameter int DIM     = asop_pkg::DIM_DEFAULT,
  parameter int MAX_NNZ = asop_pkg::MAX_NNZ_DEFAULT
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // feature_index[9:0], feature_value[25:10], label_positive[26], query_draw[42:27]
  input  wire logic [47:0]  in_tdata,
  input  wire logic         in_tlast,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // predict_positive[0], was_queried[1], was_mistake[2], was_skipped[3],
  // true_pos_count[35:4], true_neg_count[67:36], false_pos_count[99:68],
  // false_neg_count[131:100], query_count[163:132]
  output logic      [167:0] out_tdata,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [asop_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]  cfg_data
);

  localparam int AW = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int BW = (MAX_NNZ > 1) ? $clog2(MAX_NNZ) : 1;
  localparam int CW = $clog2(MAX_NNZ + 1);
  localparam int MW = asop_pkg::MUL_W;
  localparam int IW = asop_pkg::IDX_W;
  localparam int VW = asop_pkg::VAL_W;

  asop_pkg::state_t state_r, state_nxt, prev_state_r;
  logic entry;

  logic [2:0]  mode_r;
  logic [31:0] bias_r;
  logic [31:0] ocnt_r [5];
  logic signed [47:0] margin_r;
  logic [47:0] var_r;
  logic        nz_r;
  logic [CW-1:0] bcnt_r;
  logic [AW-1:0] clr_r;

  logic signed [VW-1:0] fv_r;
  logic        ypos_r;
  logic [15:0] draw_r;
  logic        last_r;

  logic [51:0] num_r;
  logic [31:0] stmp_r;
  logic [22:0] v2_r;
  logic [31:0] sig_r;
  logic        neg_r;

  logic [47:0] p_r, varc_r, x_r, mq_r;
  logic        pred_r, mis_r, qry_r, skip_r;
  logic [CW-1:0] j_r;
  logic [IW-1:0] eidx_r;
  logic signed [VW-1:0] ev_r;
  logic        out_tvalid_r;
  logic [167:0] out_tdata_r;

  // memories
  logic          ws_we;
  logic [AW-1:0] ws_waddr, ws_raddr;
  logic [63:0]   ws_wdata, ws_rdata;
  logic          bf_we;
  logic [BW-1:0] bf_waddr, bf_raddr;
  logic [asop_pkg::ENTRY_W-1:0] bf_wdata, bf_rdata;

  asop_pkg::div_req_t  div_req;
  asop_pkg::mul_req_t  mul_req;
  asop_pkg::sqrt_req_t sqrt_req;
  asop_pkg::unit_sts_t div_sts, mul_sts, sqrt_sts;
  logic [asop_pkg::DIVN_W-1:0]   div_q;
  logic [2*MW-1:0]               mul_p;
  logic [asop_pkg::DIVN_W/2-1:0] sqrt_r;

  logic [IW-1:0] in_idx;
  logic [VW-1:0] in_val;
  logic          in_acc;
  logic          in_range;

  assign in_idx   = in_tdata[9:0];
  assign in_val   = in_tdata[25:10];
  assign in_acc   = in_tvalid && in_tready;
  assign in_range = 32'(in_idx) < 32'(DIM);
  assign entry    = state_r != prev_state_r;
  assign cfg_ready = 1'b1;

  asop_ram #(.WIDTH(64), .DEPTH(DIM)) u_ws_ram (
    .clk(clk), .we(ws_we), .waddr(ws_waddr), .wdata(ws_wdata),
    .raddr(ws_raddr), .rdata(ws_rdata)
  );

  asop_ram #(.WIDTH(asop_pkg::ENTRY_W), .DEPTH(MAX_NNZ)) u_buf_ram (
    .clk(clk), .we(bf_we), .waddr(bf_waddr), .wdata(bf_wdata),
    .raddr(bf_raddr), .rdata(bf_rdata)
  );

  asop_div  u_div  (.clk(clk), .rst_n(rst_n), .req(div_req),  .quotient(div_q), .sts(div_sts));
  asop_mul  u_mul  (.clk(clk), .rst_n(rst_n), .req(mul_req),  .product(mul_p),  .sts(mul_sts));
  asop_sqrt u_sqrt (.clk(clk), .rst_n(rst_n), .req(sqrt_req), .root(sqrt_r),    .sts(sqrt_sts));

  // Forward-pass terms from the stored weight and sigma.
  logic [15:0] fmag;
  logic [31:0] fsq;
  logic [22:0] fv2;
  logic [31:0] fsig;
  logic [32:0] fstmp;
  logic [31:0] fwmag;
  logic [47:0] fprod;

  always_comb begin
    fmag  = fv_r[VW-1] ? 16'(-fv_r) : 16'(fv_r);
    fsq   = fmag * fmag;
    fv2   = fsq[30:8];
    fsig  = (ws_rdata[63:32] == 32'd0) ? 32'd1 : ws_rdata[63:32];
    fstmp = 33'(fsig) + 33'(fv2);
    fwmag = ws_rdata[31] ? 32'(-ws_rdata[31:0]) : ws_rdata[31:0];
    fprod = fwmag * fmag;
  end

  // Margin and variance accumulation.
  logic signed [52:0] msum;
  logic [48:0] vsum;

  always_comb begin
    if (neg_r) begin
      msum = 53'(margin_r) - $signed({1'b0, div_q[51:0]});
    end else begin
      msum = 53'(margin_r) + $signed({1'b0, div_q[51:0]});
    end
    vsum = 49'(var_r) + 49'(div_q[38:0]);
  end

  // End-of-example terms.
  logic signed [48:0] mext;
  logic [48:0] mabs;
  logic [47:0] pc, varc;
  logic        pred_c;
  logic [47:0] rhs;
  logic [48:0] vp;
  logic [49:0] x3;
  logic [47:0] bx;

  always_comb begin
    mext   = 49'(margin_r);
    mabs   = mext[48] ? 49'(-mext) : 49'(mext);
    pc     = (mabs > 49'(asop_pkg::QCAP)) ? asop_pkg::QCAP : mabs[47:0];
    varc   = (var_r > asop_pkg::QCAP) ? asop_pkg::QCAP : var_r;
    pred_c = !margin_r[47];
    rhs    = {bias_r, 16'h0000} - 48'(bias_r);
    vp     = 49'(varc_r) + 49'(asop_pkg::SIGMA_ONE);
    x3     = {p_r, 1'b0} + 50'(asop_pkg::cap_q(mul_p));
    bx     = 48'(bias_r) + x_r;
  end

  // Mistake update of one buffered feature.
  logic [15:0] emag;
  logic [31:0] esq;
  logic signed [33:0] edelta, nw;
  logic [32:0] ns;
  logic [31:0] nw_sat, ns_sat;

  always_comb begin
    emag   = ev_r[VW-1] ? 16'(-ev_r) : 16'(ev_r);
    esq    = emag * emag;
    edelta = 34'(ev_r) <<< 4;
    nw     = ypos_r ? 34'($signed(ws_rdata[31:0])) + edelta
                    : 34'($signed(ws_rdata[31:0])) - edelta;
    if (nw > 34'sh0_7FFF_FFFF) begin
      nw_sat = 32'h7FFF_FFFF;
    end else if (nw < -34'sh0_8000_0000) begin
      nw_sat = 32'h8000_0000;
    end else begin
      nw_sat = nw[31:0];
    end
    ns     = 33'(ws_rdata[63:32]) + 33'(esq[30:8]);
    ns_sat = ns[32] ? 32'hFFFF_FFFF : ns[31:0];
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      asop_pkg::ST_CLEAR: begin
        if (32'(clr_r) == 32'(DIM - 1)) state_nxt = asop_pkg::ST_IDLE;
      end
      asop_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_range) state_nxt = asop_pkg::ST_FRD;
          else if (in_tlast) state_nxt = asop_pkg::ST_END;
        end
      end
      asop_pkg::ST_FRD: state_nxt = asop_pkg::ST_FDIV1;
      asop_pkg::ST_FDIV1: begin
        if (div_sts.done) state_nxt = asop_pkg::ST_FDIV2;
      end
      asop_pkg::ST_FDIV2: begin
        if (div_sts.done) state_nxt = last_r ? asop_pkg::ST_END : asop_pkg::ST_IDLE;
      end
      asop_pkg::ST_END: begin
        if (!nz_r) begin
          state_nxt = asop_pkg::ST_OUT;
        end else begin
          unique case (mode_r)
            asop_pkg::MODE_MARGIN:  state_nxt = asop_pkg::ST_QMUL;
            asop_pkg::MODE_MARGVAR: state_nxt = asop_pkg::ST_M3A;
            asop_pkg::MODE_NORM:    state_nxt = asop_pkg::ST_SQRT;
            default:                state_nxt = asop_pkg::ST_DECIDE;
          endcase
        end
      end
      asop_pkg::ST_M3A: if (mul_sts.done) state_nxt = asop_pkg::ST_M3B;
      asop_pkg::ST_M3B: if (mul_sts.done) state_nxt = asop_pkg::ST_QMUL;
      asop_pkg::ST_SQRT: begin
        if (sqrt_sts.done) begin
          state_nxt = (sqrt_r == '0) ? asop_pkg::ST_QMUL : asop_pkg::ST_M4DIV;
        end
      end
      asop_pkg::ST_M4DIV: if (div_sts.done) state_nxt = asop_pkg::ST_QMUL;
      asop_pkg::ST_QMUL:  if (mul_sts.done) state_nxt = asop_pkg::ST_DECIDE;
      asop_pkg::ST_DECIDE: begin
        if (qry_r && mis_r && bcnt_r != '0) state_nxt = asop_pkg::ST_UB;
        else state_nxt = asop_pkg::ST_OUT;
      end
      asop_pkg::ST_UB: state_nxt = asop_pkg::ST_UA;
      asop_pkg::ST_UA: state_nxt = asop_pkg::ST_UW;
      asop_pkg::ST_UW: begin
        state_nxt = (j_r + CW'(1) < bcnt_r) ? asop_pkg::ST_UB : asop_pkg::ST_OUT;
      end
      asop_pkg::ST_OUT: begin
        if (!out_tvalid_r || out_tready) state_nxt = asop_pkg::ST_IDLE;
      end
      default: state_nxt = asop_pkg::ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    in_tready = 1'b0;
    ws_we     = 1'b0;
    ws_waddr  = clr_r;
    ws_wdata  = {asop_pkg::SIGMA_ONE, 32'h0000_0000};
    ws_raddr  = AW'(in_idx);
    bf_we     = 1'b0;
    bf_waddr  = bcnt_r[BW-1:0];
    bf_wdata  = {in_idx, in_val};
    bf_raddr  = j_r[BW-1:0];
    div_req   = '0;
    mul_req   = '0;
    sqrt_req  = '0;
    unique case (state_r)
      asop_pkg::ST_CLEAR: ws_we = 1'b1;
      asop_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        bf_we     = in_acc && in_range && (32'(bcnt_r) < 32'(MAX_NNZ));
      end
      asop_pkg::ST_FDIV1: begin
        div_req.start    = entry;
        div_req.dividend = 64'(num_r);
        div_req.divisor  = stmp_r;
      end
      asop_pkg::ST_FDIV2: begin
        div_req.start    = entry;
        div_req.dividend = 64'({v2_r, 16'h0000});
        div_req.divisor  = sig_r;
      end
      asop_pkg::ST_M3A: begin
        mul_req.start = entry;
        mul_req.a     = p_r;
        mul_req.b     = p_r;
      end
      asop_pkg::ST_M3B: begin
        mul_req.start = entry;
        mul_req.a     = mq_r;
        mul_req.b     = (vp > 49'(asop_pkg::QCAP)) ? asop_pkg::QCAP : vp[47:0];
      end
      asop_pkg::ST_SQRT: begin
        sqrt_req.start    = entry;
        sqrt_req.radicand = {varc_r, 16'h0000};
      end
      asop_pkg::ST_M4DIV: begin
        div_req.start    = entry;
        div_req.dividend = {p_r, 16'h0000};
        div_req.divisor  = sqrt_r;
      end
      asop_pkg::ST_QMUL: begin
        mul_req.start = entry;
        mul_req.a     = MW'(draw_r);
        mul_req.b     = bx;
      end
      asop_pkg::ST_UA: ws_raddr = AW'(bf_rdata[asop_pkg::ENTRY_W-1:VW]);
      asop_pkg::ST_UW: begin
        ws_we    = 1'b1;
        ws_waddr = AW'(eidx_r);
        ws_wdata = {ns_sat, nw_sat};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= asop_pkg::ST_CLEAR;
      prev_state_r <= asop_pkg::ST_CLEAR;
    end else begin
      state_r      <= state_nxt;
      prev_state_r <= state_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= asop_pkg::MODE_ALWAYS;
      bias_r <= asop_pkg::SIGMA_ONE;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        asop_pkg::REG_QUERY_MODE: mode_r <= cfg_data[2:0];
        asop_pkg::REG_QUERY_BIAS: bias_r <= cfg_data;
        default: ;
      endcase
    end
  end

  function automatic logic [31:0] sat_inc(input logic [31:0] c);
    sat_inc = (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
  endfunction

  // Example state and counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r        <= '0;
      margin_r     <= '0;
      var_r        <= '0;
      nz_r         <= 1'b0;
      bcnt_r       <= '0;
      out_tvalid_r <= 1'b0;
      for (int k = 0; k < 5; k++) ocnt_r[k] <= '0;
    end else begin
      if (state_r == asop_pkg::ST_OUT && (!out_tvalid_r || out_tready)) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        asop_pkg::ST_CLEAR: clr_r <= clr_r + AW'(1);
        asop_pkg::ST_IDLE: begin
          if (in_acc && in_range) begin
            if (in_val != '0) nz_r <= 1'b1;
            if (32'(bcnt_r) < 32'(MAX_NNZ)) bcnt_r <= bcnt_r + CW'(1);
          end
        end
        asop_pkg::ST_FDIV1: begin
          if (div_sts.done) begin
            if (msum > 53'sh0_7FFF_FFFF_FFFF) margin_r <= 48'sh7FFF_FFFF_FFFF;
            else if (msum < -53'sh0_8000_0000_0000) margin_r <= 48'sh8000_0000_0000;
            else margin_r <= msum[47:0];
          end
        end
        asop_pkg::ST_FDIV2: begin
          if (div_sts.done) var_r <= vsum[48] ? 48'hFFFF_FFFF_FFFF : vsum[47:0];
        end
        asop_pkg::ST_END: begin
          if (nz_r) begin
            if (pred_c == ypos_r) begin
              if (ypos_r) ocnt_r[asop_pkg::CNT_TP] <= sat_inc(ocnt_r[asop_pkg::CNT_TP]);
              else ocnt_r[asop_pkg::CNT_TN] <= sat_inc(ocnt_r[asop_pkg::CNT_TN]);
            end else begin
              if (pred_c) ocnt_r[asop_pkg::CNT_FP] <= sat_inc(ocnt_r[asop_pkg::CNT_FP]);
              else ocnt_r[asop_pkg::CNT_FN] <= sat_inc(ocnt_r[asop_pkg::CNT_FN]);
            end
          end
        end
        asop_pkg::ST_DECIDE: begin
          if (qry_r) begin
            ocnt_r[asop_pkg::CNT_QUERY] <= sat_inc(ocnt_r[asop_pkg::CNT_QUERY]);
          end
        end
        asop_pkg::ST_OUT: begin
          if (!out_tvalid_r || out_tready) begin
            margin_r     <= '0;
            var_r        <= '0;
            nz_r         <= 1'b0;
            bcnt_r       <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    unique case (state_r)
      asop_pkg::ST_IDLE: begin
        if (in_acc) begin
          fv_r   <= $signed(in_val);
          ypos_r <= in_tdata[26];
          draw_r <= in_tdata[42:27];
          last_r <= in_tlast;
        end
      end
      asop_pkg::ST_FRD: begin
        num_r  <= {fprod, 4'h0};
        stmp_r <= fstmp[32] ? 32'hFFFF_FFFF : fstmp[31:0];
        v2_r   <= fv2;
        sig_r  <= fsig;
        neg_r  <= ws_rdata[31] ^ fv_r[VW-1];
      end
      asop_pkg::ST_END: begin
        p_r    <= pc;
        varc_r <= varc;
        x_r    <= pc;
        skip_r <= !nz_r;
        pred_r <= nz_r && pred_c;
        mis_r  <= nz_r && (pred_c != ypos_r);
        j_r    <= '0;
        if (!nz_r) begin
          qry_r <= 1'b0;
        end else begin
          case (mode_r)
            asop_pkg::MODE_ALWAYS: qry_r <= 1'b1;
            asop_pkg::MODE_FIXED:  qry_r <= 48'({draw_r, 16'h0000}) <= rhs;
            default:               qry_r <= 1'b0;
          endcase
        end
      end
      asop_pkg::ST_M3A: if (mul_sts.done) mq_r <= asop_pkg::cap_q(mul_p);
      asop_pkg::ST_M3B: begin
        if (mul_sts.done) x_r <= (x3 > 50'(asop_pkg::QCAP)) ? asop_pkg::QCAP : x3[47:0];
      end
      asop_pkg::ST_SQRT: if (sqrt_sts.done && sqrt_r == '0) x_r <= asop_pkg::QCAP;
      asop_pkg::ST_M4DIV: begin
        if (div_sts.done) begin
          x_r <= (div_q > 64'(asop_pkg::QCAP)) ? asop_pkg::QCAP : div_q[47:0];
        end
      end
      asop_pkg::ST_QMUL: if (mul_sts.done) qry_r <= mul_p <= (2*MW)'(rhs);
      asop_pkg::ST_UA: begin
        eidx_r <= bf_rdata[asop_pkg::ENTRY_W-1:VW];
        ev_r   <= $signed(bf_rdata[VW-1:0]);
      end
      asop_pkg::ST_UW: j_r <= j_r + CW'(1);
      asop_pkg::ST_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tdata_r <= {4'h0, ocnt_r[asop_pkg::CNT_QUERY], ocnt_r[asop_pkg::CNT_FN],
                          ocnt_r[asop_pkg::CNT_FP], ocnt_r[asop_pkg::CNT_TN],
                          ocnt_r[asop_pkg::CNT_TP], skip_r, mis_r, qry_r, pred_r};
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule
`default_nettype wire

/* hw/rtl/asop_checker.sv */
// Port-level checks on the result channel of the perceptron block.
// Depends on active_second_order_perceptron_top_macros.svh; bound to the top level.
`default_nettype none
`include "active_second_order_perceptron_top_macros.svh"
module asop_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [167:0] out_tdata
);

  `ASOP_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "result request dropped")
  `ASOP_ASSERT_NEXT(a_out_stable, out_tvalid && !out_tready, $stable(out_tdata), "result changed")
  // A skipped example carries no prediction, query or mistake.
  `ASOP_ASSERT_NOW(a_skip_clean, out_tvalid && out_tdata[3], out_tdata[2:0] == 3'b000, "skip flags")
  // A queried example has been counted.
  `ASOP_ASSERT_NOW(a_query_cnt, out_tvalid && out_tdata[1], out_tdata[163:132] != 32'd0, "query count")

endmodule

bind active_second_order_perceptron_top asop_checker u_asop_checker (
  .clk(clk), .rst_n(rst_n), .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata)
);
`default_nettype wire
